// ===== rtl/iwh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwh_pkg
// Shared types and constants for the worm head step core: lattice geometry,
// direction codes, payload structs and the bond store request bundle.
// ----------------------------------------------------------------------------
package iwh_pkg;

	localparam int SIDE_BITS    = 6;
	localparam int LATTICE_SIDE = 1 << SIDE_BITS;
	localparam int SITE_BITS    = 2 * SIDE_BITS;
	localparam int SITE_COUNT   = LATTICE_SIDE * LATTICE_SIDE;
	localparam int DRAW_BITS    = 16;
	localparam int THR_BITS     = DRAW_BITS + 1;

	localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(1 << (DRAW_BITS - 1));

	// link direction codes
	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_LEFT  = 2'd2;
	localparam logic [1:0] DIR_RIGHT = 2'd3;

	// bit positions inside one bond row
	localparam int BOND_HORIZ = 0;
	localparam int BOND_VERT  = 1;

	typedef logic [SIDE_BITS-1:0] coord_t;
	typedef logic [SITE_BITS-1:0] site_t;
	typedef logic [1:0]           bond_row_t;

	typedef struct packed {
		logic [1:0]           direction;
		logic [DRAW_BITS-1:0] accept_draw;
		coord_t               restart_x;
		coord_t               restart_y;
		logic                 last_step;
	} step_in_t;

	typedef struct packed {
		coord_t head_col;
		coord_t head_row;
		coord_t tail_col;
		coord_t tail_row;
		logic   moved;
		logic   restarted;
		logic   sweep_done;
	} step_out_t;

	typedef struct packed {
		logic      rd;
		logic      wr;
		site_t     addr;
		bond_row_t wdata;
	} bond_req_t;

endpackage

// ===== rtl/iwh_bond_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwh_bond_mem
// Bond store: one row per site holding the vertical and horizontal link bits.
// Single port, registered read. Sweeps every row to zero after reset.
// ----------------------------------------------------------------------------
module iwh_bond_mem
	import iwh_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  bond_req_t req,
	output bond_row_t rdata,
	output logic      clearing
);

	bond_row_t mem [SITE_COUNT];

	site_t clr_addr_q;
	logic  clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == site_t'(SITE_COUNT - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= '0;
		end else if (req.wr) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd) begin
			rdata <= mem[req.addr];
		end
	end

	assign clearing = clearing_q;

endmodule

// ===== rtl/ising_worm_head_step_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ising_worm_head_step_core
// One worm-algorithm head update per command on a periodic 64 x 64 Ising
// lattice with one bond bit per link.
// ----------------------------------------------------------------------------
// After reset the core sweeps the bond store to zero, one site per cycle,
// and holds busy high until the sweep is over; threshold writes are taken
// at any time. The accept cycle of a command addresses the bond store (its
// read port is registered), the next cycle decides and writes the link back.
// The update state registers the result onto result, done high for a single
// cycle, and a new command can be accepted in that same cycle, so the core
// takes a new command only once the previous one has left its update state.
// There is no back-pressure on the result: capture it whenever done is high.
// ----------------------------------------------------------------------------
module ising_worm_head_step_core
	import iwh_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  step_in_t            cmd,
	output logic                busy,
	input  logic                cfg_we,
	input  logic [THR_BITS-1:0] cfg_wdata,
	output logic                done,
	output step_out_t           result
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE
	} state_t;

	state_t state_q;

	logic [THR_BITS-1:0]  thr_q;
	coord_t               head_x_q, head_y_q, tail_x_q, tail_y_q;
	coord_t               nx_q, ny_q;
	site_t                addr_q;
	logic                 horiz_q;
	logic [DRAW_BITS-1:0] draw_q;
	logic                 last_q;
	logic                 restarted_q;
	logic                 done_q;
	step_out_t            result_q;

	bond_req_t req;
	bond_row_t rdata;
	logic      clearing;

	logic   accept;
	logic   meet;
	coord_t bx, by, nx, ny, row, col;
	logic   link, moved;
	bond_row_t new_row;

	iwh_bond_mem u_bonds (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rdata    (rdata),
		.clearing (clearing)
	);

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// restart site and neighbor of the head for the incoming command
	always_comb begin
		meet = (head_x_q == tail_x_q) && (head_y_q == tail_y_q);
		bx   = meet ? cmd.restart_x : head_x_q;
		by   = meet ? cmd.restart_y : head_y_q;
		nx   = bx;
		ny   = by;
		row  = by;
		col  = bx;
		case (cmd.direction)
			DIR_UP: begin
				ny = by + 1'b1;
			end
			DIR_DOWN: begin
				ny  = by - 1'b1;
				row = ny;
			end
			DIR_LEFT: begin
				nx  = bx - 1'b1;
				col = nx;
			end
			DIR_RIGHT: begin
				nx = bx + 1'b1;
			end
			default: begin
				nx = bx;
			end
		endcase
	end

	// accept or toggle the selected link
	always_comb begin
		link    = horiz_q ? rdata[BOND_HORIZ] : rdata[BOND_VERT];
		moved   = link || ({1'b0, draw_q} < thr_q);
		new_row = rdata;
		if (horiz_q) begin
			new_row[BOND_HORIZ] = !link;
		end else begin
			new_row[BOND_VERT] = !link;
		end
	end

	always_comb begin
		req.rd    = accept;
		req.wr    = (state_q == ST_UPDATE) && moved;
		req.addr  = (state_q == ST_UPDATE) ? addr_q : {row, col};
		req.wdata = new_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			head_x_q <= '0;
			head_y_q <= '0;
			tail_x_q <= '0;
			tail_y_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					if (!clearing) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						head_x_q <= bx;
						head_y_q <= by;
						if (meet) begin
							tail_x_q <= cmd.restart_x;
							tail_y_q <= cmd.restart_y;
						end
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (moved) begin
						head_x_q <= nx_q;
						head_y_q <= ny_q;
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// per-command working registers and the result; no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			nx_q        <= nx;
			ny_q        <= ny;
			addr_q      <= {row, col};
			horiz_q     <= cmd.direction[1];
			draw_q      <= cmd.accept_draw;
			last_q      <= cmd.last_step;
			restarted_q <= meet;
		end
		if (state_q == ST_UPDATE) begin
			result_q.head_col   <= moved ? nx_q : head_x_q;
			result_q.head_row   <= moved ? ny_q : head_y_q;
			result_q.tail_col   <= tail_x_q;
			result_q.tail_row   <= tail_y_q;
			result_q.moved      <= moved;
			result_q.restarted  <= restarted_q;
			result_q.sweep_done <= last_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== verif/worm_step_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// worm_step_checker
// Watches the command, threshold and result ports of the worm head step core,
// keeps its own copy of the bond lattice and worm ends, predicts each step
// and compares every result field with the oldest prediction.
// ----------------------------------------------------------------------------
module worm_step_checker
	import iwh_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  step_in_t            cmd,
	input  logic                cfg_we,
	input  logic [THR_BITS-1:0] cfg_wdata,
	input  logic                done,
	input  step_out_t           result,
	output int                  fails,
	output int                  outstanding
);

	bit                  vert_bond [SITE_COUNT];
	bit                  horiz_bond [SITE_COUNT];
	coord_t              head_x, head_y, tail_x, tail_y;
	logic [THR_BITS-1:0] threshold;
	step_out_t           predicted_steps [$];
	step_out_t           want;

	function automatic step_out_t advance_worm(input step_in_t c);
		coord_t    nx, ny;
		site_t     link_site;
		logic      horiz, bond, moved, restarted;
		step_out_t r;
		restarted = (head_x == tail_x) && (head_y == tail_y);
		if (restarted) begin
			head_x = c.restart_x;
			tail_x = c.restart_x;
			head_y = c.restart_y;
			tail_y = c.restart_y;
		end
		nx = head_x;
		ny = head_y;
		horiz = 1'b0;
		link_site = {head_y, head_x};
		// links are stored at their lower-left site; coordinates wrap at 6 bits
		case (c.direction)
			DIR_UP: ny = head_y + 1'b1;
			DIR_DOWN: begin
				ny = head_y - 1'b1;
				link_site = {ny, head_x};
			end
			DIR_LEFT: begin
				nx = head_x - 1'b1;
				link_site = {head_y, nx};
				horiz = 1'b1;
			end
			default: begin
				nx = head_x + 1'b1;
				horiz = 1'b1;
			end
		endcase
		bond = horiz ? horiz_bond[link_site] : vert_bond[link_site];
		moved = bond || ({1'b0, c.accept_draw} < threshold);
		if (moved) begin
			// toggle: an occupied link is cleared, an accepted empty one is set
			if (horiz)
				horiz_bond[link_site] = !bond;
			else
				vert_bond[link_site] = !bond;
			head_x = nx;
			head_y = ny;
		end
		r.head_col   = head_x;
		r.head_row   = head_y;
		r.tail_col   = tail_x;
		r.tail_row   = tail_y;
		r.moved      = moved;
		r.restarted  = restarted;
		r.sweep_done = c.last_step;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [5:0] want_v,
		input logic [5:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want_v, got_v);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (vert_bond[i]) vert_bond[i] = 1'b0;
			foreach (horiz_bond[i]) horiz_bond[i] = 1'b0;
			head_x = '0;
			head_y = '0;
			tail_x = '0;
			tail_y = '0;
			threshold = THR_RESET;
			predicted_steps.delete();
			fails = 0;
		end else begin
			if (cfg_we)
				threshold = cfg_wdata;
			// retire before predicting: a result and a new transfer may share an edge
			if (done) begin
				if (predicted_steps.size() == 0) begin
					$display("%0t: unexpected result: expected none, got %h", $time, result);
					fails++;
				end else begin
					want = predicted_steps.pop_front();
					check_field("head_col", want.head_col, result.head_col);
					check_field("head_row", want.head_row, result.head_row);
					check_field("tail_col", want.tail_col, result.tail_col);
					check_field("tail_row", want.tail_row, result.tail_row);
					check_field("moved", want.moved, result.moved);
					check_field("restarted", want.restarted, result.restarted);
					check_field("sweep_done", want.sweep_done, result.sweep_done);
				end
			end
			if (start && !busy)
				predicted_steps.push_back(advance_worm(cmd));
		end
		outstanding = predicted_steps.size();
	end

endmodule

// ===== verif/ising_worm_head_step_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ising_worm_head_step_core_tb
// Drives worm head steps into the core: a directed walk that wraps, closes a
// loop and hits each threshold boundary, then random steps under several
// threshold settings with random gaps. A separate checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module ising_worm_head_step_core_tb;
	import iwh_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 65;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	step_in_t            cmd = '0;
	logic                cfg_we = 1'b0;
	logic [THR_BITS-1:0] cfg_wdata = '0;
	logic                busy, done;
	step_out_t           result;
	int                  fails, outstanding;
	int                  cycles = 0;
	int                  calm_left = 0;
	logic [1:0]          last_dir = DIR_UP;
	logic [THR_BITS-1:0] cur_thr = THR_RESET;

	always #1 clk = ~clk;

	ising_worm_head_step_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.busy      (busy),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.result    (result)
	);

	worm_step_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.done        (done),
		.result      (result),
		.fails       (fails),
		.outstanding (outstanding)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic step_in_t make_step(input logic [1:0] dir, input logic [15:0] draw,
		input coord_t rx, input coord_t ry, input logic last);
		step_in_t c;
		c.direction   = dir;
		c.accept_draw = draw;
		c.restart_x   = rx;
		c.restart_y   = ry;
		c.last_step   = last;
		return c;
	endfunction

	function automatic step_in_t random_step();
		logic [1:0]  dir;
		logic [15:0] draw;
		// reverse the previous link often so the worm retraces and clears bonds
		if ($urandom_range(0, 2) == 0)
			dir = last_dir ^ 2'b01;
		else
			dir = 2'($urandom_range(0, 3));
		case ($urandom_range(0, 7))
			0: draw = 16'h0000;
			1: draw = 16'hFFFF;
			2: draw = 16'(cur_thr + $urandom_range(0, 4) - 2);
			default: draw = 16'($urandom);
		endcase
		return make_step(dir, draw, coord_t'($urandom_range(0, 63)),
			coord_t'($urandom_range(0, 63)), $urandom_range(0, 15) == 0);
	endfunction

	// entered just after a falling edge; returns just after a falling edge
	task automatic send_step(input step_in_t c);
		int gap;
		if (calm_left > 0) begin
			calm_left--;
			gap = 0;
		end else begin
			if ($urandom_range(0, 9) == 0)
				calm_left = $urandom_range(8, 24);
			gap = $urandom_range(0, 15);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		last_dir = c.direction;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic settle();
		start <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	task automatic write_threshold(input logic [THR_BITS-1:0] v);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		cur_thr = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	logic [THR_BITS-1:0] phase_thr [7];

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// walk off both lattice edges, retrace, then close a four-link loop
		send_step(make_step(DIR_UP, 16'h0000, 6'd63, 6'd63, 1'b1));
		send_step(make_step(DIR_DOWN, 16'hFFFF, 6'd0, 6'd0, 1'b0));
		send_step(make_step(DIR_RIGHT, 16'hFFFF, 6'd0, 6'd0, 1'b1));
		send_step(make_step(DIR_LEFT, 16'd32767, 6'd63, 6'd0, 1'b0));
		send_step(make_step(DIR_DOWN, 16'd32768, 6'd21, 6'd42, 1'b0));
		send_step(make_step(DIR_DOWN, 16'h0000, 6'd42, 6'd21, 1'b0));
		send_step(make_step(DIR_RIGHT, 16'h0000, 6'd0, 6'd0, 1'b0));
		send_step(make_step(DIR_UP, 16'h0000, 6'd0, 6'd0, 1'b1));
		send_step(make_step(DIR_RIGHT, 16'hFFFF, 6'd0, 6'd63, 1'b0));

		// nothing new accepted, occupied links still clear
		write_threshold('0);
		send_step(make_step(DIR_LEFT, 16'h0000, 6'd63, 6'd0, 1'b1));
		send_step(make_step(DIR_UP, 16'h0000, 6'd0, 6'd0, 1'b0));
		send_step(make_step(DIR_DOWN, 16'hFFFF, 6'd0, 6'd0, 1'b0));

		write_threshold(17'd65536);
		send_step(make_step(DIR_LEFT, 16'hFFFF, 6'd0, 6'd0, 1'b0));
		send_step(make_step(DIR_RIGHT, 16'hFFFF, 6'd0, 6'd0, 1'b1));

		write_threshold(17'h1FFFF);
		send_step(make_step(DIR_UP, 16'hFFFF, 6'd0, 6'd0, 1'b0));
		send_step(make_step(DIR_DOWN, 16'h8000, 6'd0, 6'd0, 1'b0));

		write_threshold(17'd1);
		send_step(make_step(DIR_LEFT, 16'd1, 6'd0, 6'd0, 1'b0));
		send_step(make_step(DIR_LEFT, 16'd0, 6'd0, 6'd0, 1'b1));

		phase_thr[0] = THR_RESET;
		phase_thr[1] = THR_BITS'($urandom_range(0, 131071));
		phase_thr[2] = 17'd65536;
		phase_thr[3] = '0;
		phase_thr[4] = 17'h1FFFF;
		phase_thr[5] = 17'd1;
		phase_thr[6] = THR_BITS'($urandom_range(0, 65536));
		for (int p = 0; p < 7; p++) begin
			write_threshold(phase_thr[p]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send_step(random_step());
				// hold off mid-phase until the pipe is empty
				if (p == 1 && i == PHASE_ITEMS / 2)
					settle();
			end
		end

		settle();
		repeat (8) @(negedge clk);
		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/iwh_pkg.sv
rtl/iwh_bond_mem.sv
rtl/ising_worm_head_step_core.sv
verif/worm_step_checker.sv
verif/ising_worm_head_step_core_tb.sv
